[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/ppt_pkg.sv]
package ppt_pkg;

	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF    = 16;

	localparam int DELAY_BITS = 16;
	localparam int ADDR_BITS  = 5;
	localparam int DATA_BITS  = 32;
	localparam int CODE_BITS  = 9;

	// padded bounds: floor(min * 108 / 100), floor(max * 92 / 100)
	localparam int PAD_MIN_MUL   = 108;
	localparam int PAD_MAX_MUL   = 92;
	localparam int PAD_DIV       = 100;
	localparam int PAD_GUARD     = 7;
	localparam int PAD_REM_BITS  = 7;

	localparam int CODE_SCALE  = 390;
	localparam int CODE_OFFSET = 60;

	localparam int NUM_TIMERS   = 4;
	localparam int TMR_A1       = 0;
	localparam int TMR_A2       = 1;
	localparam int TMR_BRAKE    = 2;
	localparam int TMR_DISAGREE = 3;

	localparam int RANGE_MIN_RST   = 0;
	localparam int RANGE_MAX_RST   = 4095;
	localparam int BRAKE_PRESS_RST = 2048;
	localparam int DELAY_RST       = 100;

	typedef enum logic [2:0] {
		REG_A1_MIN,
		REG_A1_MAX,
		REG_A2_MIN,
		REG_A2_MAX,
		REG_BRAKE_MIN,
		REG_BRAKE_MAX,
		REG_BRAKE_PRESS,
		REG_DELAY
	} ppt_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_SETUP,
		S_DIV,
		S_MAP,
		S_OUT
	} ppt_state_t;

	typedef struct packed {
		logic load;
		logic pad_step;
		logic setup;
		logic div_step;
	} ppt_lane_ctrl_t;

	typedef struct packed {
		logic                  tick;
		logic                  drive;
		logic [NUM_TIMERS-1:0] cond;
	} ppt_timer_ctrl_t;

endpackage

[src/pedal_plausibility_throttle_map.sv]
// Sequence: a reading's transaction steps through S_PAD, S_SETUP, S_DIV and S_MAP after
//  acceptance and then waits in S_OUT; a tick's transaction goes from acceptance to S_OUT.
// Throughput: one transaction at a time, taken only in S_IDLE; a reading's pace is set by
//  the bit-serial divide-by-100 of the padded bounds and the bit-serial fraction divider.
//  A full output register holds the next result and the input.
// Reset: arst_n clears control, fault timers and registers to defaults at once.
`include "assert_macros.svh"

module pedal_plausibility_throttle_map #(
	parameter int SAMPLE_BITS   = ppt_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = ppt_pkg::FRACTION_BITS_DEF,
	parameter int TIMER_BITS    = ppt_pkg::TIMER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppt_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [ppt_pkg::DATA_BITS-1:0]   pwdata,
	output logic [ppt_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [SAMPLE_BITS-1:0]          accel_one_sample,
	input  logic [SAMPLE_BITS-1:0]          accel_two_sample,
	input  logic [SAMPLE_BITS-1:0]          brake_sample,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            throttle_valid,
	output logic [ppt_pkg::CODE_BITS-1:0]   throttle_code,
	output logic                            accel_one_range_fault,
	output logic                            accel_two_range_fault,
	output logic                            brake_range_fault,
	output logic                            pedal_disagree_fault,
	output logic                            brake_plausibility_fault,
	output logic                            brake_plausibility_cleared
);

	localparam int PW      = SAMPLE_BITS + ppt_pkg::PAD_GUARD;
	localparam int CNT_MAX = (PW > FRACTION_BITS) ? PW : FRACTION_BITS;
	localparam int CNT_W   = $clog2(CNT_MAX);
	localparam int FB      = FRACTION_BITS + 1;
	localparam int SW      = FRACTION_BITS + 2;
	localparam int MW      = FRACTION_BITS + 5;
	localparam int PRW     = FRACTION_BITS + 10;
	localparam int CB      = ppt_pkg::CODE_BITS;
	localparam int NT      = ppt_pkg::NUM_TIMERS;

	localparam logic [MW-1:0] ONE_W   = MW'(1) << FRACTION_BITS;
	localparam logic [FB-1:0] QUARTER = FB'(1) << (FRACTION_BITS - 2);

	// configuration
	logic [SAMPLE_BITS-1:0]         cfg_a1_min, cfg_a1_max, cfg_a2_min, cfg_a2_max;
	logic [SAMPLE_BITS-1:0]         cfg_br_min, cfg_br_max, cfg_br_press;
	logic [ppt_pkg::DELAY_BITS-1:0] cfg_delay;

	// control
	ppt_pkg::ppt_state_t       state_q, state_nx;
	logic [CNT_W-1:0]          cnt_q;
	logic                      in_accept, out_load, pad_last, div_last;
	ppt_pkg::ppt_lane_ctrl_t   lane_ctrl;
	ppt_pkg::ppt_timer_ctrl_t  tmr_ctrl;
	logic [NT-1:0]             tmr_cond;
	logic [NT-1:0]             tmr_expire;
	logic                      tick_q;

	// captured reading
	logic [SAMPLE_BITS-1:0]    a1_q, a2_q, br_q;

	// mapping
	logic [FB-1:0]             f1, f2, diff;
	logic [SW-1:0]             sum;
	logic                      press, pl_fault, pl_clear;
	logic [FB-1:0]             avg_q;
	logic                      pl_fault_q, pl_clear_q;
	logic [NT-1:0]             expire_q;
	logic [PRW-1:0]            prod;
	logic [CB-1:0]             code_calc;

	// output register
	logic                      out_valid_q, throttle_valid_q;
	logic [CB-1:0]             code_q;
	logic [NT-1:0]             range_fault_q;
	logic                      pl_fault_out_q, pl_clear_out_q;

	ppt_regs #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.accel_one_min     (cfg_a1_min),
		.accel_one_max     (cfg_a1_max),
		.accel_two_min     (cfg_a2_min),
		.accel_two_max     (cfg_a2_max),
		.brake_min         (cfg_br_min),
		.brake_max         (cfg_br_max),
		.brake_press_level (cfg_br_press),
		.fault_delay_ticks (cfg_delay)
	);

	// Each lane turns one accelerator sample into a fraction: padded bounds first,
	// one bit per cycle, then the fraction, one quotient bit per cycle.
	ppt_lane #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_lane_one (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (a1_q),
		.lo     (cfg_a1_min),
		.hi     (cfg_a1_max),
		.frac   (f1)
	);

	ppt_lane #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_lane_two (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (a2_q),
		.lo     (cfg_a2_min),
		.hi     (cfg_a2_max),
		.frac   (f2)
	);

	ppt_timers #(
		.TIMER_BITS(TIMER_BITS)
	) u_timers (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tmr_ctrl),
		.delay  (cfg_delay),
		.expire (tmr_expire)
	);

	// ------------------------------------------------------------------
	// Sequencer: one transaction at a time.
	// ------------------------------------------------------------------
	assign in_accept = in_valid && in_ready;
	assign out_load  = (state_q == ppt_pkg::S_OUT) && (!out_valid_q || out_ready);
	assign pad_last  = cnt_q == CNT_W'(PW - 1);
	assign div_last  = cnt_q == CNT_W'(FRACTION_BITS - 1);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ppt_pkg::S_IDLE: begin
				if (in_accept) begin
					state_nx = kind ? ppt_pkg::S_OUT : ppt_pkg::S_PAD;
				end
			end
			ppt_pkg::S_PAD: begin
				if (pad_last) begin
					state_nx = ppt_pkg::S_SETUP;
				end
			end
			ppt_pkg::S_SETUP: state_nx = ppt_pkg::S_DIV;
			ppt_pkg::S_DIV: begin
				if (div_last) begin
					state_nx = ppt_pkg::S_MAP;
				end
			end
			ppt_pkg::S_MAP: state_nx = ppt_pkg::S_OUT;
			ppt_pkg::S_OUT: begin
				if (out_load) begin
					state_nx = ppt_pkg::S_IDLE;
				end
			end
			default: state_nx = ppt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready           = state_q == ppt_pkg::S_IDLE;
		lane_ctrl.load     = in_accept && !kind;
		lane_ctrl.pad_step = state_q == ppt_pkg::S_PAD;
		lane_ctrl.setup    = state_q == ppt_pkg::S_SETUP;
		lane_ctrl.div_step = state_q == ppt_pkg::S_DIV;
		tmr_ctrl.tick      = in_accept && kind;
		tmr_ctrl.drive     = state_q == ppt_pkg::S_MAP;
		tmr_ctrl.cond      = tmr_cond;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppt_pkg::S_IDLE;
			cnt_q   <= '0;
			tick_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			// advance the bit counter only through the serial phases
			if ((state_q == ppt_pkg::S_PAD && !pad_last) ||
				(state_q == ppt_pkg::S_DIV && !div_last)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (in_accept) begin
				tick_q <= kind;
			end
		end
	end

	// hold the raw samples for the lanes and the range checks
	always_ff @(posedge clk) begin
		if (in_accept) begin
			a1_q <= accel_one_sample;
			a2_q <= accel_two_sample;
			br_q <= brake_sample;
		end
		// a tick advances the timers at acceptance: hold what expired
		if (tmr_ctrl.tick) begin
			expire_q <= tmr_expire;
		end
	end

	// ------------------------------------------------------------------
	// Checks and average, taken once both fractions are final.
	// ------------------------------------------------------------------
	assign sum      = SW'(f1) + SW'(f2);
	assign diff     = (f1 > f2) ? f1 - f2 : f2 - f1;
	assign press    = br_q >= cfg_br_press;
	assign pl_fault = press && (f1 >= QUARTER) && (f2 >= QUARTER);
	assign pl_clear = !pl_fault && (MW'(f1) * MW'(20) < ONE_W) && (MW'(f2) * MW'(20) < ONE_W);

	always_comb begin
		tmr_cond = '0;
		tmr_cond[ppt_pkg::TMR_A1]       = (a1_q < cfg_a1_min) || (a1_q > cfg_a1_max);
		tmr_cond[ppt_pkg::TMR_A2]       = (a2_q < cfg_a2_min) || (a2_q > cfg_a2_max);
		tmr_cond[ppt_pkg::TMR_BRAKE]    = (br_q < cfg_br_min) || (br_q > cfg_br_max);
		tmr_cond[ppt_pkg::TMR_DISAGREE] = MW'(diff) * MW'(10) > ONE_W;
	end

	always_ff @(posedge clk) begin
		if (state_q == ppt_pkg::S_MAP) begin
			avg_q      <= sum[SW-1:1];
			pl_fault_q <= pl_fault;
			pl_clear_q <= pl_clear;
		end
	end

	// code = floor(390 * avg / one) + 60, at most 450
	assign prod      = PRW'(avg_q) * PRW'(ppt_pkg::CODE_SCALE);
	assign code_calc = CB'(prod >> FRACTION_BITS) + CB'(ppt_pkg::CODE_OFFSET);

	// ------------------------------------------------------------------
	// Output register: load when empty or being drained, drop when taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			throttle_valid_q <= !tick_q;
			code_q           <= tick_q ? CB'(0) : code_calc;
			range_fault_q    <= tick_q ? expire_q : '0;
			pl_fault_out_q   <= !tick_q && pl_fault_q;
			pl_clear_out_q   <= !tick_q && pl_clear_q;
		end
	end

	assign out_valid                  = out_valid_q;
	assign throttle_valid             = throttle_valid_q;
	assign throttle_code              = code_q;
	assign accel_one_range_fault      = range_fault_q[ppt_pkg::TMR_A1];
	assign accel_two_range_fault      = range_fault_q[ppt_pkg::TMR_A2];
	assign brake_range_fault          = range_fault_q[ppt_pkg::TMR_BRAKE];
	assign pedal_disagree_fault       = range_fault_q[ppt_pkg::TMR_DISAGREE];
	assign brake_plausibility_fault   = pl_fault_out_q;
	assign brake_plausibility_cleared = pl_clear_out_q;

	`ASSERT_CLK(a_code_range, clk, arst_n, out_valid_q && throttle_valid_q |-> code_q >= CB'(ppt_pkg::CODE_OFFSET) && code_q <= CB'(ppt_pkg::CODE_OFFSET + ppt_pkg::CODE_SCALE), "throttle code out of range")
	`ASSERT_NEVER(a_plaus_excl, clk, arst_n, out_valid_q && pl_fault_out_q && pl_clear_out_q, "plausibility fault and clear together")
	`ASSERT_NEVER(a_reading_no_expiry, clk, arst_n, out_valid_q && throttle_valid_q && (range_fault_q != '0), "timer expiry on a reading")

endmodule

[src/ppt_regs.sv]
module ppt_regs #(
	parameter int SAMPLE_BITS = ppt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ppt_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [ppt_pkg::DATA_BITS-1:0]    pwdata,
	output logic [ppt_pkg::DATA_BITS-1:0]    prdata,
	output logic                             pready,
	output logic [SAMPLE_BITS-1:0]           accel_one_min,
	output logic [SAMPLE_BITS-1:0]           accel_one_max,
	output logic [SAMPLE_BITS-1:0]           accel_two_min,
	output logic [SAMPLE_BITS-1:0]           accel_two_max,
	output logic [SAMPLE_BITS-1:0]           brake_min,
	output logic [SAMPLE_BITS-1:0]           brake_max,
	output logic [SAMPLE_BITS-1:0]           brake_press_level,
	output logic [ppt_pkg::DELAY_BITS-1:0]   fault_delay_ticks
);

	ppt_pkg::ppt_reg_t reg_idx;
	logic              wr_en;

	logic [SAMPLE_BITS-1:0]         a1_min_q, a1_max_q, a2_min_q, a2_max_q;
	logic [SAMPLE_BITS-1:0]         br_min_q, br_max_q, br_press_q;
	logic [ppt_pkg::DELAY_BITS-1:0] delay_q;

	assign reg_idx = ppt_pkg::ppt_reg_t'(paddr[ppt_pkg::ADDR_BITS-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_min_q   <= SAMPLE_BITS'(ppt_pkg::RANGE_MIN_RST);
			a1_max_q   <= SAMPLE_BITS'(ppt_pkg::RANGE_MAX_RST);
			a2_min_q   <= SAMPLE_BITS'(ppt_pkg::RANGE_MIN_RST);
			a2_max_q   <= SAMPLE_BITS'(ppt_pkg::RANGE_MAX_RST);
			br_min_q   <= SAMPLE_BITS'(ppt_pkg::RANGE_MIN_RST);
			br_max_q   <= SAMPLE_BITS'(ppt_pkg::RANGE_MAX_RST);
			br_press_q <= SAMPLE_BITS'(ppt_pkg::BRAKE_PRESS_RST);
			delay_q    <= ppt_pkg::DELAY_BITS'(ppt_pkg::DELAY_RST);
		end else if (wr_en) begin
			unique case (reg_idx)
				ppt_pkg::REG_A1_MIN:      a1_min_q   <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_A1_MAX:      a1_max_q   <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_A2_MIN:      a2_min_q   <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_A2_MAX:      a2_max_q   <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_BRAKE_MIN:   br_min_q   <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_BRAKE_MAX:   br_max_q   <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_BRAKE_PRESS: br_press_q <= pwdata[SAMPLE_BITS-1:0];
				ppt_pkg::REG_DELAY:       delay_q    <= pwdata[ppt_pkg::DELAY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ppt_pkg::REG_A1_MIN:      prdata = ppt_pkg::DATA_BITS'(a1_min_q);
			ppt_pkg::REG_A1_MAX:      prdata = ppt_pkg::DATA_BITS'(a1_max_q);
			ppt_pkg::REG_A2_MIN:      prdata = ppt_pkg::DATA_BITS'(a2_min_q);
			ppt_pkg::REG_A2_MAX:      prdata = ppt_pkg::DATA_BITS'(a2_max_q);
			ppt_pkg::REG_BRAKE_MIN:   prdata = ppt_pkg::DATA_BITS'(br_min_q);
			ppt_pkg::REG_BRAKE_MAX:   prdata = ppt_pkg::DATA_BITS'(br_max_q);
			ppt_pkg::REG_BRAKE_PRESS: prdata = ppt_pkg::DATA_BITS'(br_press_q);
			ppt_pkg::REG_DELAY:       prdata = ppt_pkg::DATA_BITS'(delay_q);
			default:                  prdata = '0;
		endcase
	end

	assign accel_one_min     = a1_min_q;
	assign accel_one_max     = a1_max_q;
	assign accel_two_min     = a2_min_q;
	assign accel_two_max     = a2_max_q;
	assign brake_min         = br_min_q;
	assign brake_max         = br_max_q;
	assign brake_press_level = br_press_q;
	assign fault_delay_ticks = delay_q;

endmodule

[src/ppt_lane.sv]
module ppt_lane #(
	parameter int SAMPLE_BITS   = ppt_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = ppt_pkg::FRACTION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ppt_pkg::ppt_lane_ctrl_t ctrl,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  logic [SAMPLE_BITS-1:0]  lo,
	input  logic [SAMPLE_BITS-1:0]  hi,
	output logic [FRACTION_BITS:0]  frac
);

	localparam int PW = SAMPLE_BITS + ppt_pkg::PAD_GUARD;
	localparam int BW = SAMPLE_BITS + 1;
	localparam int RB = ppt_pkg::PAD_REM_BITS;
	localparam int RW = RB + 1;

	// one restoring step of the divide by 100: {quotient bit, new remainder}
	function automatic logic [RW-1:0] bound_div_step(input logic [RB-1:0] rem,
		input logic din);
		logic [RW-1:0] t;
		t = {rem, din};
		if (t >= RW'(ppt_pkg::PAD_DIV)) begin
			bound_div_step = {1'b1, RB'(t - RW'(ppt_pkg::PAD_DIV))};
		end else begin
			bound_div_step = {1'b0, t[RB-1:0]};
		end
	endfunction

	// dividend shifts out at the top, quotient shifts in at the bottom
	logic [PW-1:0]            pmin_sh_q, pmax_sh_q;
	logic [RB-1:0]            pmin_rem_q, pmax_rem_q;
	logic [RW-1:0]            pmin_nx, pmax_nx;

	logic [BW-1:0]            pmin, pmax, s_ext, x_val, d_val, div_t, div_sub;
	logic                     below, above, empty, full, div_ge;

	logic [SAMPLE_BITS-1:0]   rem_q, dsr_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic                     spec_q, spec_one_q;

	assign pmin_nx = bound_div_step(pmin_rem_q, pmin_sh_q[PW-1]);
	assign pmax_nx = bound_div_step(pmax_rem_q, pmax_sh_q[PW-1]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pmin_sh_q  <= PW'(lo) * PW'(ppt_pkg::PAD_MIN_MUL);
			pmax_sh_q  <= PW'(hi) * PW'(ppt_pkg::PAD_MAX_MUL);
			pmin_rem_q <= '0;
			pmax_rem_q <= '0;
		end else if (ctrl.pad_step) begin
			pmin_sh_q  <= {pmin_sh_q[PW-2:0], pmin_nx[RW-1]};
			pmax_sh_q  <= {pmax_sh_q[PW-2:0], pmax_nx[RW-1]};
			pmin_rem_q <= pmin_nx[RB-1:0];
			pmax_rem_q <= pmax_nx[RB-1:0];
		end
	end

	assign pmin  = pmin_sh_q[BW-1:0];
	assign pmax  = pmax_sh_q[BW-1:0];
	assign s_ext = BW'(sample);
	assign below = s_ext < pmin;
	assign above = s_ext > pmax;
	assign empty = pmax == pmin;
	assign x_val = s_ext - pmin;
	assign d_val = pmax - pmin;
	assign full  = x_val == d_val;

	assign div_t   = {rem_q, 1'b0};
	assign div_ge  = div_t >= BW'(dsr_q);
	assign div_sub = div_ge ? div_t - BW'(dsr_q) : div_t;

	always_ff @(posedge clk) begin
		if (ctrl.setup) begin
			rem_q <= x_val[SAMPLE_BITS-1:0];
			dsr_q <= d_val[SAMPLE_BITS-1:0];
			quo_q <= '0;
		end else if (ctrl.div_step) begin
			rem_q <= div_sub[SAMPLE_BITS-1:0];
			quo_q <= {quo_q[FRACTION_BITS-2:0], div_ge};
		end
	end

	// below pmin wins, then above pmax, then the empty range, then a full-scale sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_q     <= 1'b0;
			spec_one_q <= 1'b0;
		end else if (ctrl.setup) begin
			spec_q     <= below || above || empty || full;
			spec_one_q <= !below && (above || (!empty && full));
		end
	end

	assign frac = spec_q ? {spec_one_q, FRACTION_BITS'(0)} : {1'b0, quo_q};

endmodule

[src/ppt_timers.sv]
`include "assert_macros.svh"

module ppt_timers #(
	parameter int TIMER_BITS = ppt_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ppt_pkg::ppt_timer_ctrl_t         ctrl,
	input  logic [ppt_pkg::DELAY_BITS-1:0]   delay,
	output logic [ppt_pkg::NUM_TIMERS-1:0]   expire
);

	localparam int NT = ppt_pkg::NUM_TIMERS;
	localparam int DB = ppt_pkg::DELAY_BITS;
	localparam int CW = (TIMER_BITS > DB) ? TIMER_BITS : DB;
	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	logic [TIMER_BITS-1:0] count_q [NT];
	logic [TIMER_BITS-1:0] cnt_inc [NT];
	logic [NT-1:0]         running_q;
	logic [NT-1:0]         hit;
	logic [DB-1:0]         delay_eff;

	assign delay_eff = (delay == '0) ? DB'(1) : delay;

	always_comb begin
		for (int i = 0; i < NT; i++) begin
			cnt_inc[i] = (count_q[i] == TMAX) ? count_q[i] : count_q[i] + TIMER_BITS'(1);
			hit[i]     = CW'(cnt_inc[i]) >= CW'(delay_eff);
			expire[i]  = ctrl.tick && running_q[i] && hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				count_q[i] <= '0;
			end
			running_q <= '0;
		end else begin
			for (int i = 0; i < NT; i++) begin
				if (ctrl.tick) begin
					if (running_q[i]) begin
						if (hit[i]) begin
							running_q[i] <= 1'b0;
							count_q[i]   <= '0;
						end else begin
							count_q[i] <= cnt_inc[i];
						end
					end
				end else if (ctrl.drive) begin
					// a persisting condition keeps a running timer going
					if (ctrl.cond[i]) begin
						if (!running_q[i]) begin
							running_q[i] <= 1'b1;
							count_q[i]   <= '0;
						end
					end else begin
						running_q[i] <= 1'b0;
						count_q[i]   <= '0;
					end
				end
			end
		end
	end

	`ASSERT_NEVER(a_tick_and_drive, clk, arst_n, ctrl.tick && ctrl.drive, "tick and drive together")

	for (genvar g = 0; g < NT; g++) begin : g_chk
		`ASSERT_CLK(a_stopped_zero, clk, arst_n, !running_q[g] |-> count_q[g] == '0, "stopped timer not zero")
	end

endmodule

[tb/tb_pedal_plausibility_throttle_map.sv]
`timescale 1ns / 1ps

module tb_pedal_plausibility_throttle_map;
	import ppt_pkg::*;

	// Input transaction kinds.
	localparam logic KIND_READING = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	localparam longint unsigned FRAC_ONE = 64'd1 << FRACTION_BITS_DEF;
	localparam int unsigned TIMER_MAX = (1 << TIMER_BITS_DEF) - 1;

	localparam int CLK_HALF          = 10;
	localparam int RESET_CYCLES      = 7;
	localparam int LIMIT_CYCLES      = 1_000_000;
	// Reading latency plus margin, used for the final quiet stretch.
	localparam int DRAIN_CYCLES      = SAMPLE_BITS_DEF + FRACTION_BITS_DEF + 20;
	localparam int SETTINGS_PER_PHASE = 6;
	localparam int ITEMS_PER_SETTING  = 97;
	localparam int HOLD_OFF_CYCLES    = 400;
	localparam int DIRECTED_LEN       = 30;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_op_e;

	typedef struct packed {
		logic                 throttle_valid;
		logic [CODE_BITS-1:0] throttle_code;
		logic                 accel_one_range_fault;
		logic                 accel_two_range_fault;
		logic                 brake_range_fault;
		logic                 pedal_disagree_fault;
		logic                 brake_plausibility_fault;
		logic                 brake_plausibility_cleared;
	} pedal_result_t;

	// One row of the directed table: either a register write or a transaction.
	// flags = {a1 range, a2 range, brake range, disagree, plaus fault, plaus cleared}
	typedef struct packed {
		row_op_e              op;
		ppt_reg_t             sel;
		logic [15:0]          value;
		logic                 kind;
		logic [11:0]          a1;
		logic [11:0]          a2;
		logic [11:0]          br;
		logic                 typed;
		logic [CODE_BITS-1:0] code;
		logic [5:0]           flags;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic                  kind;
	logic [11:0]           accel_one_sample;
	logic [11:0]           accel_two_sample;
	logic [11:0]           brake_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic                  throttle_valid;
	logic [CODE_BITS-1:0]  throttle_code;
	logic                  accel_one_range_fault;
	logic                  accel_two_range_fault;
	logic                  brake_range_fault;
	logic                  pedal_disagree_fault;
	logic                  brake_plausibility_fault;
	logic                  brake_plausibility_cleared;

	// Shadow copy of the registers and of the fault timers.
	int unsigned reg_shadow [8];
	int unsigned timer_count [NUM_TIMERS];
	bit          timer_running [NUM_TIMERS];

	pedal_result_t expected_results [$];
	int            mismatches = 0;

	// Sender / receiver control shared between processes.
	int            send_idle = 38;
	int            recv_idle = 52;
	int            hold_req  = 0;
	logic          row_typed;
	pedal_result_t row_expect;

	stim_row_t directed_rows [DIRECTED_LEN] = '{
		// right after reset: a tick with nothing running
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 9'd0, 6'b000000},
		// all zero: lowest code, pedals released
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd0, 12'd0, 12'd0,
			1'b1, 9'd60, 6'b000001},
		// all full scale: highest code, brake pressed with pedals down
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd4095, 12'd4095, 12'd4095,
			1'b1, 9'd450, 6'b000010},
		// sensors disagree completely: half code, disagreement timer starts
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd4095, 12'd0, 12'd2048,
			1'b1, 9'd255, 6'b000000},
		'{ROW_CFG, REG_DELAY, 16'd2, KIND_READING, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		// condition persists: the running timer keeps its count
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd4095, 12'd0, 12'd2048,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		// raw range check uses the unpadded bound
		'{ROW_CFG, REG_A1_MIN, 16'd100, KIND_READING, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd50, 12'd50, 12'd4095,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd104, 12'd104, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		// zero delay behaves as one tick
		'{ROW_CFG, REG_DELAY, 16'd0, KIND_READING, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_CFG, REG_BRAKE_MAX, 16'd3000, KIND_READING, 12'd0, 12'd0, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd2000, 12'd2000, 12'd3001,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		// empty padded range on the second sensor
		'{ROW_CFG, REG_A2_MAX, 16'd0, KIND_READING, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd2000, 12'd0, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd2000, 12'd1, 12'd0,
			1'b0, 9'd0, 6'b0},
		// inverted padded range: below-minimum test wins
		'{ROW_CFG, REG_A2_MIN, 16'd3600, KIND_READING, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_CFG, REG_A2_MAX, 16'd4095, KIND_READING, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd0, 12'd3800, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd0, 12'd4000, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0},
		// brake bounds and press level at the extremes
		'{ROW_CFG, REG_BRAKE_MIN, 16'd4095, KIND_READING, 12'd0, 12'd0, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_CFG, REG_BRAKE_PRESS, 16'd0, KIND_READING, 12'd0, 12'd0, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd4095, 12'd4095, 12'd4095,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_READING, 12'd4095, 12'd4095, 12'd0,
			1'b0, 9'd0, 6'b0},
		'{ROW_ITEM, REG_A1_MIN, 16'd0, KIND_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 9'd0, 6'b0}
	};

	pedal_plausibility_throttle_map dut (
		.clk                        (clk),
		.arst_n                     (arst_n),
		.psel                       (psel),
		.penable                    (penable),
		.pwrite                     (pwrite),
		.paddr                      (paddr),
		.pwdata                     (pwdata),
		.prdata                     (prdata),
		.pready                     (pready),
		.in_valid                   (in_valid),
		.in_ready                   (in_ready),
		.kind                       (kind),
		.accel_one_sample           (accel_one_sample),
		.accel_two_sample           (accel_two_sample),
		.brake_sample               (brake_sample),
		.out_valid                  (out_valid),
		.out_ready                  (out_ready),
		.throttle_valid             (throttle_valid),
		.throttle_code              (throttle_code),
		.accel_one_range_fault      (accel_one_range_fault),
		.accel_two_range_fault      (accel_two_range_fault),
		.brake_range_fault          (brake_range_fault),
		.pedal_disagree_fault       (pedal_disagree_fault),
		.brake_plausibility_fault   (brake_plausibility_fault),
		.brake_plausibility_cleared (brake_plausibility_cleared)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Stop a hung run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Pedal fraction: clamp into the padded range, scale to Q1.16.
	function automatic longint unsigned pedal_fraction(logic [11:0] s, int unsigned lo,
			int unsigned hi);
		longint unsigned pmin;
		longint unsigned pmax;
		longint unsigned sv;
		pmin = longint'(lo) * PAD_MIN_MUL / PAD_DIV;
		pmax = longint'(hi) * PAD_MAX_MUL / PAD_DIV;
		sv = s;
		if (sv < pmin)
			return 0;
		if (sv > pmax)
			return FRAC_ONE;
		if (pmax == pmin)
			return 0;
		return ((sv - pmin) << FRACTION_BITS_DEF) / (pmax - pmin);
	endfunction

	// Start a stopped timer when the condition shows; stop it when it goes away.
	function automatic void arm_fault_timer(int idx, bit cond);
		if (cond) begin
			if (!timer_running[idx]) begin
				timer_running[idx] = 1'b1;
				timer_count[idx] = 0;
			end
		end else begin
			timer_running[idx] = 1'b0;
			timer_count[idx] = 0;
		end
	endfunction

	// Work out the result of one transaction and advance the shadow timers.
	function automatic pedal_result_t predict_pedal_result(logic k, logic [11:0] s1,
			logic [11:0] s2, logic [11:0] sb);
		pedal_result_t r;
		longint unsigned f1;
		longint unsigned f2;
		longint unsigned avg;
		longint unsigned diff;
		int unsigned delay;
		logic [NUM_TIMERS-1:0] fired;
		r = '0;
		if (k == KIND_TICK) begin
			delay = (reg_shadow[REG_DELAY] == 0) ? 1 : reg_shadow[REG_DELAY];
			fired = '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (timer_running[i]) begin
					if (timer_count[i] < TIMER_MAX)
						timer_count[i]++;
					if (timer_count[i] >= delay) begin
						fired[i] = 1'b1;
						timer_running[i] = 1'b0;
						timer_count[i] = 0;
					end
				end
			end
			r.accel_one_range_fault = fired[TMR_A1];
			r.accel_two_range_fault = fired[TMR_A2];
			r.brake_range_fault     = fired[TMR_BRAKE];
			r.pedal_disagree_fault  = fired[TMR_DISAGREE];
			return r;
		end
		f1 = pedal_fraction(s1, reg_shadow[REG_A1_MIN], reg_shadow[REG_A1_MAX]);
		f2 = pedal_fraction(s2, reg_shadow[REG_A2_MIN], reg_shadow[REG_A2_MAX]);
		avg = (f1 + f2) >> 1;
		diff = (f1 > f2) ? f1 - f2 : f2 - f1;
		arm_fault_timer(TMR_A1, s1 < reg_shadow[REG_A1_MIN] || s1 > reg_shadow[REG_A1_MAX]);
		arm_fault_timer(TMR_A2, s2 < reg_shadow[REG_A2_MIN] || s2 > reg_shadow[REG_A2_MAX]);
		arm_fault_timer(TMR_BRAKE,
			sb < reg_shadow[REG_BRAKE_MIN] || sb > reg_shadow[REG_BRAKE_MAX]);
		arm_fault_timer(TMR_DISAGREE, diff * 10 > FRAC_ONE);
		r.throttle_valid = 1'b1;
		r.throttle_code = CODE_BITS'(((longint'(CODE_SCALE) * avg) >> FRACTION_BITS_DEF)
			+ CODE_OFFSET);
		if (sb >= reg_shadow[REG_BRAKE_PRESS] && f1 * 4 >= FRAC_ONE && f2 * 4 >= FRAC_ONE)
			r.brake_plausibility_fault = 1'b1;
		else if (f1 * 20 < FRAC_ONE && f2 * 20 < FRAC_ONE)
			r.brake_plausibility_cleared = 1'b1;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Scoreboard: retire results first, then record newly accepted transactions.
	always @(posedge clk) begin : result_check
		pedal_result_t want;
		pedal_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.throttle_valid             = throttle_valid;
				got.throttle_code              = throttle_code;
				got.accel_one_range_fault      = accel_one_range_fault;
				got.accel_two_range_fault      = accel_two_range_fault;
				got.brake_range_fault          = brake_range_fault;
				got.pedal_disagree_fault       = pedal_disagree_fault;
				got.brake_plausibility_fault   = brake_plausibility_fault;
				got.brake_plausibility_cleared = brake_plausibility_cleared;
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("throttle_valid", want.throttle_valid, got.throttle_valid);
					check_field("throttle_code", want.throttle_code, got.throttle_code);
					check_field("accel_one_range_fault", want.accel_one_range_fault,
						got.accel_one_range_fault);
					check_field("accel_two_range_fault", want.accel_two_range_fault,
						got.accel_two_range_fault);
					check_field("brake_range_fault", want.brake_range_fault,
						got.brake_range_fault);
					check_field("pedal_disagree_fault", want.pedal_disagree_fault,
						got.pedal_disagree_fault);
					check_field("brake_plausibility_fault", want.brake_plausibility_fault,
						got.brake_plausibility_fault);
					check_field("brake_plausibility_cleared",
						want.brake_plausibility_cleared, got.brake_plausibility_cleared);
				end
			end
			if (in_valid && in_ready) begin
				// The predictor always runs so the shadow timers stay in step; a typed
				// table row then overrides the expectation.
				want = predict_pedal_result(kind, accel_one_sample, accel_two_sample,
					brake_sample);
				if (row_typed)
					want = row_expect;
				expected_results.push_back(want);
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (hold_req > 0) begin
				hold_left = hold_req - 1;
				hold_req = 0;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Hold until every expected result has come back.
	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Two-phase register write; the shadow updates at the access edge.
	task automatic write_reg(ppt_reg_t sel, int unsigned value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {sel, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		reg_shadow[sel] = (sel == REG_DELAY) ? (value & 32'hFFFF) : (value & 32'hFFF);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Offer one transaction; call and return at a falling edge.
	task automatic offer_item(logic k, logic [11:0] s1, logic [11:0] s2, logic [11:0] sb,
			logic typed, pedal_result_t want);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		accel_one_sample = s1;
		accel_two_sample = s2;
		brake_sample = sb;
		row_typed = typed;
		row_expect = want;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [11:0] clamp_sample(int v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'd4095;
		return v[11:0];
	endfunction

	// Sample biased toward the bounds and padded bounds of one sensor.
	function automatic logic [11:0] pick_sample(int unsigned lo, int unsigned hi);
		int v;
		case ($urandom_range(9))
			0: v = $urandom_range(0, 4095);
			1: v = lo;
			2: v = hi;
			3: v = int'(lo) - 1;
			4: v = int'(hi) + 1;
			5: v = int'(lo * PAD_MIN_MUL / PAD_DIV) + int'($urandom_range(0, 2)) - 1;
			6: v = int'(hi * PAD_MAX_MUL / PAD_DIV) + int'($urandom_range(0, 2)) - 1;
			default: v = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(lo, hi);
		endcase
		return clamp_sample(v);
	endfunction

	// Mostly readings within or near the configured ranges, with ticks mixed in
	// so the fault timers actually run and expire.
	task automatic next_random_item(output logic k, output logic [11:0] s1,
			output logic [11:0] s2, output logic [11:0] sb);
		k = ($urandom_range(99) < 30) ? KIND_TICK : KIND_READING;
		s1 = pick_sample(reg_shadow[REG_A1_MIN], reg_shadow[REG_A1_MAX]);
		// keep the second sensor close to the first often enough to agree
		if ($urandom_range(2) == 0)
			s2 = clamp_sample(int'(s1) + int'($urandom_range(0, 400)) - 200);
		else
			s2 = pick_sample(reg_shadow[REG_A2_MIN], reg_shadow[REG_A2_MAX]);
		if ($urandom_range(1) == 0)
			sb = pick_sample(reg_shadow[REG_BRAKE_MIN], reg_shadow[REG_BRAKE_MAX]);
		else
			sb = clamp_sample(int'(reg_shadow[REG_BRAKE_PRESS])
				+ int'($urandom_range(0, 40)) - 20);
	endtask

	// Write a full register set once the block is idle. The first three sets hold
	// the extremes; the rest are random with short fault delays, but for set 3, which has the longest.
	task automatic apply_setting(int idx);
		int unsigned vals [8];
		int unsigned lo;
		int unsigned hi;
		int unsigned tmp;
		case (idx)
			0: vals = '{0, 4095, 0, 4095, 0, 4095, 2048, 1};
			1: vals = '{4095, 4095, 0, 0, 0, 0, 0, 3};
			2: vals = '{0, 4095, 0, 4095, 0, 4095, 4095, 0};
			default: begin
				for (int j = 0; j < 3; j++) begin
					lo = $urandom_range(1500, 0);
					hi = $urandom_range(4095, 2500);
					// now and then an inverted range
					if ($urandom_range(7) == 0) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end
					vals[2 * j] = lo;
					vals[2 * j + 1] = hi;
				end
				vals[REG_BRAKE_PRESS] = $urandom_range(4095, 0);
				vals[REG_DELAY] = (idx == 3) ? 65535 : $urandom_range(6, 1);
			end
		endcase
		in_valid = 1'b0;
		wait_drained();
		for (int j = 0; j < 8; j++)
			write_reg(ppt_reg_t'(j), vals[j]);
	endtask

	initial begin : stimulus
		logic [11:0]   s1;
		logic [11:0]   s2;
		logic [11:0]   sb;
		logic          k;
		pedal_result_t want;

		// Drive every input to a known value before reset.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		kind = KIND_READING;
		accel_one_sample = '0;
		accel_two_sample = '0;
		brake_sample = '0;
		row_typed = 1'b0;
		row_expect = '0;
		reg_shadow = '{RANGE_MIN_RST, RANGE_MAX_RST, RANGE_MIN_RST, RANGE_MAX_RST,
			RANGE_MIN_RST, RANGE_MAX_RST, BRAKE_PRESS_RST, DELAY_RST};
		for (int i = 0; i < NUM_TIMERS; i++) begin
			timer_count[i] = 0;
			timer_running[i] = 1'b0;
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table under the first idling mix.
		send_idle = 38;
		recv_idle = 52;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_CFG) begin
				in_valid = 1'b0;
				wait_drained();
				write_reg(directed_rows[i].sel, directed_rows[i].value);
			end else begin
				want.throttle_valid = (directed_rows[i].kind == KIND_READING);
				want.throttle_code = directed_rows[i].code;
				{want.accel_one_range_fault, want.accel_two_range_fault,
					want.brake_range_fault, want.pedal_disagree_fault,
					want.brake_plausibility_fault, want.brake_plausibility_cleared}
					= directed_rows[i].flags;
				offer_item(directed_rows[i].kind, directed_rows[i].a1, directed_rows[i].a2,
					directed_rows[i].br, directed_rows[i].typed, want);
			end
		end

		// Random part: three idling mixes, several register sets in each.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 38;
					recv_idle = 52;
				end
				1: begin
					send_idle = 52;
					recv_idle = 38;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int st = 0; st < SETTINGS_PER_PHASE; st++) begin
				apply_setting(ph * SETTINGS_PER_PHASE + st);
				for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
					// Long receiver hold-off while we keep offering: fills the block
					// and stalls its input.
					if (ph == 0 && st == 1 && n == 0)
						hold_req = HOLD_OFF_CYCLES;
					// Drop valid and let everything drain mid-stream.
					if (ph == 1 && st == 2 && n == ITEMS_PER_SETTING / 2) begin
						in_valid = 1'b0;
						wait_drained();
					end
					next_random_item(k, s1, s2, sb);
					offer_item(k, s1, s2, sb, 1'b0, '0);
				end
			end
		end

		in_valid = 1'b0;
		wait_drained();
		// Quiet stretch to catch any stray result.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[pedal_plausibility_throttle_map.f]
+incdir+src
src/ppt_pkg.sv
src/ppt_regs.sv
src/ppt_lane.sv
src/ppt_timers.sv
src/pedal_plausibility_throttle_map.sv
tb/tb_pedal_plausibility_throttle_map.sv
